// File: rtl/assert_macros.svh
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_PROP(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");

`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition seen");

`else

`define ASSERT_PROP(label, clk, rst_n, prop)

`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// File: rtl/mtk_pkg.sv
package mtk_pkg;

    localparam int TEXT_LENGTH = 32;

    localparam int POS_W    = $clog2(TEXT_LENGTH);
    localparam int CUR_W    = $clog2(TEXT_LENGTH + 1);
    localparam int KEY_W    = 5;
    localparam int CHAR_W   = 8;
    localparam int TAP_W    = 2;
    localparam int IDLE_W   = 8;
    localparam int EFFECT_W = 3;

    localparam logic [IDLE_W-1:0] IDLE_TIMEOUT_RESET = 8'd120;
    localparam logic [TAP_W-1:0]  TAP_WRAP           = 2'd3;

    // key codes
    localparam logic [KEY_W-1:0] KEY_NONE = 5'd0;
    localparam logic [KEY_W-1:0] KEY_D0   = 5'd1;
    localparam logic [KEY_W-1:0] KEY_D1   = 5'd2;
    localparam logic [KEY_W-1:0] KEY_D2   = 5'd3;
    localparam logic [KEY_W-1:0] KEY_D3   = 5'd4;
    localparam logic [KEY_W-1:0] KEY_D4   = 5'd5;
    localparam logic [KEY_W-1:0] KEY_D5   = 5'd6;
    localparam logic [KEY_W-1:0] KEY_D6   = 5'd7;
    localparam logic [KEY_W-1:0] KEY_D7   = 5'd8;
    localparam logic [KEY_W-1:0] KEY_D8   = 5'd9;
    localparam logic [KEY_W-1:0] KEY_D9   = 5'd10;
    localparam logic [KEY_W-1:0] KEY_A    = 5'd11;
    localparam logic [KEY_W-1:0] KEY_D    = 5'd14;
    localparam logic [KEY_W-1:0] KEY_STAR = 5'd15;
    localparam logic [KEY_W-1:0] KEY_HASH = 5'd16;

    localparam logic [KEY_W-1:0] KEY_ERASE     = KEY_D1;
    localparam logic [KEY_W-1:0] KEY_EFFECT_OF = 5'd10;

    typedef struct packed {
        logic                wr_valid;
        logic [POS_W-1:0]    wr_pos;
        logic [CHAR_W-1:0]   wr_char;
        logic                cleared;
        logic                saved;
        logic [EFFECT_W-1:0] effect;
    } res_t;

    function automatic logic [CHAR_W-1:0] first_letter(input logic [KEY_W-1:0] key);
        logic [CHAR_W-1:0] ch;
        case (key)
            KEY_D0:  ch = "Z";
            KEY_D2:  ch = "A";
            KEY_D3:  ch = "D";
            KEY_D4:  ch = "G";
            KEY_D5:  ch = "J";
            KEY_D6:  ch = "M";
            KEY_D7:  ch = "P";
            KEY_D8:  ch = "T";
            KEY_D9:  ch = "W";
            default: ch = '0;
        endcase
        return ch;
    endfunction

endpackage

// File: rtl/multitap_keypad_text_entry.sv
// Channel   Handshake                         Payload
// key       key_valid / key_stall             key_sample
// result    result_valid / result_stall       write_valid .. idle_flag
// config    idle_timeout_we                   idle_timeout_wdata
//
// A sample passes the states accept, evaluate and emit; a letter key adds a second
// evaluate, as the text RAM is read at the cursor, then at the cursor after any timeout advance.
// Hash adds, before the emit, a sweep over all TEXT_LENGTH cells that zeroes the text RAM.
// After reset the same sweep runs with key_stall high.
// A result waiting under result_stall holds back only the emit of the next one.
`include "assert_macros.svh"

module multitap_keypad_text_entry (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          idle_timeout_we,
    input  logic [mtk_pkg::IDLE_W-1:0]    idle_timeout_wdata,
    input  logic                          key_valid,
    output logic                          key_stall,
    input  logic [mtk_pkg::KEY_W-1:0]     key_sample,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic                          write_valid,
    output logic [mtk_pkg::POS_W-1:0]     write_position,
    output logic [mtk_pkg::CHAR_W-1:0]    write_char,
    output logic [mtk_pkg::CUR_W-1:0]     cursor,
    output logic                          text_cleared,
    output logic                          text_saved,
    output logic [mtk_pkg::EFFECT_W-1:0]  effect_select,
    output logic                          idle_flag
);

    import mtk_pkg::*;

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_EVAL  = 3'd2;
    localparam logic [2:0] S_EVAL2 = 3'd3;
    localparam logic [2:0] S_EMIT  = 3'd4;

    localparam logic [CUR_W-1:0] CUR_LEN  = CUR_W'(TEXT_LENGTH);
    localparam logic [POS_W-1:0] POS_LAST = POS_W'(TEXT_LENGTH - 1);

    logic [2:0]          state_reg,        state_next;
    logic [POS_W-1:0]    clr_cnt_reg,      clr_cnt_next;
    logic                clr_emit_reg,     clr_emit_next;
    logic [KEY_W-1:0]    key_reg,          key_next;
    logic                changed_reg,      changed_next;
    logic [KEY_W-1:0]    prev_sample_reg,  prev_sample_next;
    logic [KEY_W-1:0]    prev_letter_reg,  prev_letter_next;
    logic [CUR_W-1:0]    cursor_reg,       cursor_next;
    logic [TAP_W-1:0]    tap_reg,          tap_next;
    logic [IDLE_W-1:0]   idle_reg,         idle_next;
    logic [IDLE_W-1:0]   timeout_reg;
    res_t                pend_reg,         pend_next;
    res_t                out_reg,          out_next;
    logic [CUR_W-1:0]    out_cursor_reg,   out_cursor_next;
    logic                out_idle_reg,     out_idle_next;
    logic                result_valid_reg, result_valid_next;

    logic                ram_we;
    logic [POS_W-1:0]    ram_waddr;
    logic [CHAR_W-1:0]   ram_wdata;
    logic [POS_W-1:0]    ram_raddr;
    logic [CHAR_W-1:0]   ram_rdata;

    logic                accept;
    logic                out_free;
    logic                in_range;
    logic                occupied;
    logic                is_letter;
    logic                timed_out;
    logic [CHAR_W-1:0]   base;
    logic [TAP_W-1:0]    tap1;
    logic [TAP_W-1:0]    tap2;
    logic [CUR_W-1:0]    cur1;
    logic [CUR_W-1:0]    cur2;

    mtk_ram #(
        .WIDTH (CHAR_W),
        .DEPTH (TEXT_LENGTH)
    ) u_text_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign accept   = key_valid && !key_stall;
    assign out_free = !result_valid_reg || !result_stall;

    assign in_range  = cursor_reg < CUR_LEN;
    assign occupied  = in_range && (ram_rdata != '0);
    assign is_letter = (key_reg inside {[KEY_D0:KEY_D9]}) && (key_reg != KEY_ERASE);
    assign timed_out = idle_reg > timeout_reg;
    assign base      = first_letter(key_reg);
    assign tap1      = ((key_reg == KEY_D0) || (tap_reg == TAP_WRAP)) ? '0 : tap_reg;
    assign tap2      = timed_out ? '0 : tap1;
    assign cur1      = cursor_reg + CUR_W'(timed_out && occupied);
    assign cur2      = cursor_reg + CUR_W'(occupied);

    always_comb
    begin
        state_next        = state_reg;
        clr_cnt_next      = clr_cnt_reg;
        clr_emit_next     = clr_emit_reg;
        key_next          = key_reg;
        changed_next      = changed_reg;
        prev_sample_next  = prev_sample_reg;
        prev_letter_next  = prev_letter_reg;
        cursor_next       = cursor_reg;
        tap_next          = tap_reg;
        idle_next         = idle_reg;
        pend_next         = pend_reg;
        out_next          = out_reg;
        out_cursor_next   = out_cursor_reg;
        out_idle_next     = out_idle_reg;
        result_valid_next = result_valid_reg && result_stall;

        ram_we    = 1'b0;
        ram_waddr = cursor_reg[POS_W-1:0];
        ram_wdata = '0;
        ram_raddr = cursor_reg[POS_W-1:0];

        case (state_reg)
            S_CLEAR:
            begin
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == POS_LAST)
                begin
                    clr_cnt_next = '0;
                    state_next   = clr_emit_reg ? S_EMIT : S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next         = key_sample;
                    changed_next     = key_sample != prev_sample_reg;
                    prev_sample_next = key_sample;
                    state_next       = S_EVAL;
                end
            end
            S_EVAL:
            begin
                pend_next  = '0;
                state_next = S_EMIT;
                if (changed_reg)
                begin
                    if (key_reg == KEY_ERASE)
                    begin
                        if (in_range)
                        begin
                            ram_we            = 1'b1;
                            pend_next.wr_valid = 1'b1;
                            pend_next.wr_pos   = cursor_reg[POS_W-1:0];
                        end
                        if (cursor_reg != '0)
                        begin
                            cursor_next = cursor_reg - 1'b1;
                        end
                    end
                    else if (is_letter)
                    begin
                        cursor_next = cur1;
                        tap_next    = tap2;
                        ram_raddr   = cur1[POS_W-1:0];
                        state_next  = S_EVAL2;
                    end
                    else if (key_reg inside {[KEY_A:KEY_D]})
                    begin
                        pend_next.effect = EFFECT_W'(key_reg - KEY_EFFECT_OF);
                    end
                    else if (key_reg == KEY_STAR)
                    begin
                        pend_next.saved = 1'b1;
                    end
                    else if (key_reg == KEY_HASH)
                    begin
                        cursor_next       = '0;
                        pend_next.cleared = 1'b1;
                        clr_cnt_next      = '0;
                        clr_emit_next     = 1'b1;
                        state_next        = S_CLEAR;
                    end
                end
            end
            S_EVAL2:
            begin
                if (in_range)
                begin
                    if (prev_letter_reg == key_reg)
                    begin
                        ram_we             = 1'b1;
                        ram_wdata          = base + CHAR_W'(tap_reg);
                        pend_next.wr_valid = 1'b1;
                        pend_next.wr_pos   = cursor_reg[POS_W-1:0];
                        pend_next.wr_char  = base + CHAR_W'(tap_reg);
                        tap_next           = tap_reg + 1'b1;
                    end
                    else
                    begin
                        cursor_next = cur2;
                        if (cur2 < CUR_LEN)
                        begin
                            ram_we             = 1'b1;
                            ram_waddr          = cur2[POS_W-1:0];
                            ram_wdata          = base;
                            pend_next.wr_valid = 1'b1;
                            pend_next.wr_pos   = cur2[POS_W-1:0];
                            pend_next.wr_char  = base;
                            tap_next           = TAP_W'(1);
                        end
                    end
                end
                prev_letter_next = key_reg;
                idle_next        = '0;
                state_next       = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_next          = pend_reg;
                    out_cursor_next   = cursor_reg;
                    out_idle_next     = idle_reg > timeout_reg;
                    result_valid_next = 1'b1;
                    if (idle_reg != '1)
                    begin
                        idle_next = idle_reg + 1'b1;
                    end
                    clr_emit_next = 1'b0;
                    state_next    = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_cnt_reg      <= '0;
            clr_emit_reg     <= 1'b0;
            prev_sample_reg  <= KEY_NONE;
            prev_letter_reg  <= KEY_NONE;
            cursor_reg       <= '0;
            tap_reg          <= '0;
            idle_reg         <= '0;
            timeout_reg      <= IDLE_TIMEOUT_RESET;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_cnt_reg      <= clr_cnt_next;
            clr_emit_reg     <= clr_emit_next;
            prev_sample_reg  <= prev_sample_next;
            prev_letter_reg  <= prev_letter_next;
            cursor_reg       <= cursor_next;
            tap_reg          <= tap_next;
            idle_reg         <= idle_next;
            result_valid_reg <= result_valid_next;
            if (idle_timeout_we)
            begin
                timeout_reg <= idle_timeout_wdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        changed_reg    <= changed_next;
        pend_reg       <= pend_next;
        out_reg        <= out_next;
        out_cursor_reg <= out_cursor_next;
        out_idle_reg   <= out_idle_next;
    end

    assign key_stall      = state_reg != S_IDLE;
    assign result_valid   = result_valid_reg;
    assign write_valid    = out_reg.wr_valid;
    assign write_position = out_reg.wr_pos;
    assign write_char     = out_reg.wr_char;
    assign cursor         = out_cursor_reg;
    assign text_cleared   = out_reg.cleared;
    assign text_saved     = out_reg.saved;
    assign effect_select  = out_reg.effect;
    assign idle_flag      = out_idle_reg;

    `ASSERT_NEVER(a_cursor_range, clk, rst_n, cursor_reg > CUR_LEN)
    `ASSERT_PROP(a_accept_to_eval, clk, rst_n, accept |=> state_reg == S_EVAL)
    `ASSERT_NEVER(a_we_busy, clk, rst_n, ram_we && (state_reg == S_IDLE || state_reg == S_EMIT))
    `ASSERT_PROP(a_rv_from_emit, clk, rst_n, $rose(result_valid_reg) |-> $past(state_reg) == S_EMIT)

endmodule

// File: rtl/mtk_ram.sv
module mtk_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule
